### sv/ogx_pkg.sv
// ----------------------------------------------------------------------------
// ogx_pkg
// Shared types, register codes and direction tables for the outline geometry
// expander.
// ----------------------------------------------------------------------------
package ogx_pkg;

   localparam int POS_W         = 24;
   localparam int POSN_W        = 14;
   localparam int TEX_W         = 32;
   localparam int ALPHA_W       = 8;
   localparam int IDX_IN_W      = 12;
   localparam int IDX_OUT_W     = 16;
   localparam int SLOT_W        = 18;
   localparam int RGB_W         = 24;
   localparam int VCOUNT_W      = 13;
   localparam int ICOUNT_W      = 15;
   localparam int COPY_W        = 4;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 32;

   localparam int MAX_VERTICES  = 4096;
   localparam int MAX_INDICES   = 16384;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_EIGHT    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MULT_ALPHA   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_Y     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_Z     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTLINE_COLOR = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_COUNT = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_COUNT  = 3'd6;
   // index with no register behind it
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_REG       = 3'd7;

   // item kinds
   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_INDEX  = 1'b1;

   // direction of one offset component
   localparam logic [1:0] DIR_ZERO = 2'd0;
   localparam logic [1:0] DIR_POS  = 2'd1;
   localparam logic [1:0] DIR_NEG  = 2'd2;

   typedef struct packed {
      logic                       use_eight;
      logic                       mult_alpha;
      logic signed [POS_W-1:0]    offset_y;
      logic signed [POS_W-1:0]    offset_z;
      logic [CSR_DATA_W-1:0]      outline_color;
      logic [VCOUNT_W-1:0]        vertex_count;
      logic [ICOUNT_W-1:0]        index_count;
   } cfg_type;

   typedef struct packed {
      logic                       mode;
      logic [POSN_W-1:0]          position;
      logic signed [POS_W-1:0]    pos_x;
      logic signed [POS_W-1:0]    pos_y;
      logic signed [POS_W-1:0]    pos_z;
      logic [TEX_W-1:0]           texcoord;
      logic [ALPHA_W-1:0]         alpha;
      logic [IDX_IN_W-1:0]        index_in;
   } entry_type;

   // copy order: (+,+) (-,+) (+,-) (-,-) (-,0) (+,0) (0,+) (0,-)
   function automatic logic [1:0] dir_y(input logic [2:0] k);
      logic [1:0] d;
      unique case (k)
         3'd0, 3'd2, 3'd5: d = DIR_POS;
         3'd1, 3'd3, 3'd4: d = DIR_NEG;
         default:          d = DIR_ZERO;
      endcase
      return d;
   endfunction

   function automatic logic [1:0] dir_z(input logic [2:0] k);
      logic [1:0] d;
      unique case (k)
         3'd0, 3'd1, 3'd6: d = DIR_POS;
         3'd2, 3'd3, 3'd7: d = DIR_NEG;
         default:          d = DIR_ZERO;
      endcase
      return d;
   endfunction

   // shift a coordinate by a signed offset and clamp to the coordinate range
   function automatic logic signed [POS_W-1:0] shift_sat(
      input logic signed [POS_W-1:0] v,
      input logic signed [POS_W-1:0] off,
      input logic [1:0]              d);
      logic signed [POS_W:0] term;
      logic signed [POS_W:0] sum;
      logic signed [POS_W-1:0] r;
      unique case (d)
         DIR_POS: term = {off[POS_W-1], off};
         DIR_NEG: term = -{off[POS_W-1], off};
         default: term = '0;
      endcase
      sum = {v[POS_W-1], v} + term;
      if (sum[POS_W] != sum[POS_W-1]) begin
         r = sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
         r = sum[POS_W-1:0];
      end
      return r;
   endfunction

endpackage

### sv/ogx_csr.sv
// ----------------------------------------------------------------------------
// ogx_csr
// Configuration registers with write-time clamping of the mesh counts.
// ----------------------------------------------------------------------------
module ogx_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ogx_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ogx_pkg::CSR_DATA_W-1:0]    csr_data,
   output ogx_pkg::cfg_type                  cfg
);

   ogx_pkg::cfg_type cfg_ff, cfg_in;
   logic [ogx_pkg::VCOUNT_W-1:0] vc_raw;
   logic [ogx_pkg::ICOUNT_W-1:0] ic_raw;

   assign csr_ready = 1'b1;
   assign vc_raw = csr_data[ogx_pkg::VCOUNT_W-1:0];
   assign ic_raw = csr_data[ogx_pkg::ICOUNT_W-1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ogx_pkg::CSR_USE_EIGHT:     cfg_in.use_eight  = csr_data[0];
            ogx_pkg::CSR_MULT_ALPHA:    cfg_in.mult_alpha = csr_data[0];
            ogx_pkg::CSR_OFFSET_Y:      cfg_in.offset_y   = csr_data[ogx_pkg::POS_W-1:0];
            ogx_pkg::CSR_OFFSET_Z:      cfg_in.offset_z   = csr_data[ogx_pkg::POS_W-1:0];
            ogx_pkg::CSR_OUTLINE_COLOR: cfg_in.outline_color = csr_data;
            ogx_pkg::CSR_VERTEX_COUNT: begin
               cfg_in.vertex_count = (vc_raw > ogx_pkg::VCOUNT_W'(ogx_pkg::MAX_VERTICES))
                  ? ogx_pkg::VCOUNT_W'(ogx_pkg::MAX_VERTICES) : vc_raw;
            end
            ogx_pkg::CSR_INDEX_COUNT: begin
               cfg_in.index_count = (ic_raw > ogx_pkg::ICOUNT_W'(ogx_pkg::MAX_INDICES))
                  ? ogx_pkg::ICOUNT_W'(ogx_pkg::MAX_INDICES) : ic_raw;
            end
            default: ;  // drop writes to unknown registers
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.use_eight     <= 1'b0;
         cfg_ff.mult_alpha    <= 1'b0;
         cfg_ff.offset_y      <= 24'sd256;
         cfg_ff.offset_z      <= 24'sd256;
         cfg_ff.outline_color <= 32'hFF00_0000;
         cfg_ff.vertex_count  <= '0;
         cfg_ff.index_count   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   a_vc_bound: assert property (@(posedge clock) disable iff (reset)
      cfg_ff.vertex_count <= ogx_pkg::VCOUNT_W'(ogx_pkg::MAX_VERTICES))
      else $error("vertex count above bound");
   a_ic_bound: assert property (@(posedge clock) disable iff (reset)
      cfg_ff.index_count <= ogx_pkg::ICOUNT_W'(ogx_pkg::MAX_INDICES))
      else $error("index count above bound");
   a_unknown_ignored: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_index == ogx_pkg::CSR_NO_REG) |=> $stable(cfg_ff))
      else $error("write to unknown register changed configuration");

endmodule

### sv/ogx_front.sv
// ----------------------------------------------------------------------------
// ogx_front
// Input stage: accepts items, drops them while the mesh is empty and
// precomputes the outline alpha.
// ----------------------------------------------------------------------------
module ogx_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ogx_pkg::cfg_type                        cfg,
   input  logic                                    req_push,
   output logic                                    req_full,
   input  logic                                    req_mode,
   input  logic [ogx_pkg::POSN_W-1:0]              req_item_position,
   input  logic signed [ogx_pkg::POS_W-1:0]        req_pos_x,
   input  logic signed [ogx_pkg::POS_W-1:0]        req_pos_y,
   input  logic signed [ogx_pkg::POS_W-1:0]        req_pos_z,
   input  logic [ogx_pkg::TEX_W-1:0]               req_texcoord,
   input  logic [ogx_pkg::ALPHA_W-1:0]             req_source_alpha,
   input  logic [ogx_pkg::IDX_IN_W-1:0]            req_index_in,
   output logic                                    q_push,
   output ogx_pkg::entry_type                      q_entry,
   input  logic                                    q_full
);

   logic                 valid_ff, valid_in;
   ogx_pkg::entry_type   entry_ff;
   logic                 accept;
   logic                 move;
   logic                 mesh_empty;
   logic [ogx_pkg::ALPHA_W-1:0]   base_alpha;
   logic [2*ogx_pkg::ALPHA_W-1:0] product;
   logic [2*ogx_pkg::ALPHA_W:0]   scaled;
   logic [ogx_pkg::ALPHA_W-1:0]   alpha;

   assign mesh_empty = (cfg.vertex_count == '0) || (cfg.index_count == '0);
   assign move       = valid_ff && !q_full;
   assign req_full   = valid_ff && q_full;
   assign accept     = req_push && !req_full;

   // floor(p / 255) as (p + (p >> 8) + 1) >> 8, exact below 65535
   assign base_alpha = cfg.outline_color[ogx_pkg::CSR_DATA_W-1 -: ogx_pkg::ALPHA_W];
   assign product    = req_source_alpha * base_alpha;
   assign scaled     = {1'b0, product} + (2*ogx_pkg::ALPHA_W+1)'(product >> 8) + 1'b1;
   assign alpha      = cfg.mult_alpha ? scaled[2*ogx_pkg::ALPHA_W-1:ogx_pkg::ALPHA_W]
                                      : base_alpha;

   always_comb begin
      if (accept) begin
         valid_in = !mesh_empty;
      end else if (move) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff.mode     <= req_mode;
         entry_ff.position <= req_item_position;
         entry_ff.pos_x    <= req_pos_x;
         entry_ff.pos_y    <= req_pos_y;
         entry_ff.pos_z    <= req_pos_z;
         entry_ff.texcoord <= req_texcoord;
         entry_ff.alpha    <= alpha;
         entry_ff.index_in <= req_index_in;
      end
   end

   assign q_push  = move;
   assign q_entry = entry_ff;

   a_drop_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && mesh_empty) |=> !valid_ff)
      else $error("item taken while mesh is empty");
   a_keep_stalled: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && q_full) |=> (valid_ff && $stable(entry_ff)))
      else $error("stalled beat lost");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("push into full queue");

endmodule

### sv/ogx_queue.sv
// ----------------------------------------------------------------------------
// ogx_queue
// Two-entry queue between the input stage and the expansion stage.
// ----------------------------------------------------------------------------
module ogx_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ogx_pkg::entry_type   push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output ogx_pkg::entry_type   head
);

   ogx_pkg::entry_type store_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue count out of range");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

### sv/ogx_back.sv
// ----------------------------------------------------------------------------
// ogx_back
// Expansion stage: walks the copies of the head item into the result register,
// one result per cycle while that register is free or being popped.
// ----------------------------------------------------------------------------
module ogx_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ogx_pkg::cfg_type                     cfg,
   input  logic                                 q_valid,
   input  ogx_pkg::entry_type                   q_head,
   output logic                                 q_pop,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic                                 rsp_kind,
   output logic [ogx_pkg::SLOT_W-1:0]           rsp_slot,
   output logic signed [ogx_pkg::POS_W-1:0]     rsp_out_x,
   output logic signed [ogx_pkg::POS_W-1:0]     rsp_out_y,
   output logic signed [ogx_pkg::POS_W-1:0]     rsp_out_z,
   output logic [ogx_pkg::TEX_W-1:0]            rsp_out_texcoord,
   output logic [ogx_pkg::RGB_W-1:0]            rsp_out_rgb,
   output logic [ogx_pkg::ALPHA_W-1:0]          rsp_out_alpha,
   output logic [ogx_pkg::IDX_OUT_W-1:0]        rsp_index_out,
   output logic                                 rsp_last
);

   logic [ogx_pkg::COPY_W-1:0]    k_ff, k_in;
   logic [ogx_pkg::SLOT_W-1:0]    slot_ff, slot_in;
   logic [ogx_pkg::IDX_OUT_W-1:0] idx_ff, idx_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic                          out_free;
   logic                          step;
   logic                          is_index;
   logic                          first;
   logic                          last;
   logic [ogx_pkg::COPY_W-1:0]    copies;
   logic [ogx_pkg::SLOT_W-1:0]    vc_wide;
   logic [ogx_pkg::SLOT_W-1:0]    stride;
   logic [ogx_pkg::SLOT_W-1:0]    slot_cur;
   logic [ogx_pkg::IDX_OUT_W-1:0] idx_vc;
   logic [ogx_pkg::IDX_OUT_W-1:0] idx_cur;

   assign out_free = !rsp_valid_ff || rsp_pop;
   assign step     = q_valid && out_free;
   assign is_index = (q_head.mode == ogx_pkg::KIND_INDEX);
   assign first    = (k_ff == '0);
   assign copies   = cfg.use_eight ? ogx_pkg::COPY_W'(8) : ogx_pkg::COPY_W'(4);
   assign last     = is_index ? (k_ff == copies) : (k_ff == copies - 1'b1);
   assign q_pop    = step && last;

   assign vc_wide  = ogx_pkg::SLOT_W'(cfg.vertex_count);
   assign stride   = is_index ? ogx_pkg::SLOT_W'(cfg.index_count) : vc_wide;
   assign idx_vc   = ogx_pkg::IDX_OUT_W'(cfg.vertex_count);

   // running sums replace the k * count products
   always_comb begin
      if (first) begin
         slot_cur = is_index ? ogx_pkg::SLOT_W'(q_head.position)
                             : vc_wide + ogx_pkg::SLOT_W'(q_head.position);
         idx_cur  = ogx_pkg::IDX_OUT_W'(q_head.index_in) + idx_vc;
      end else begin
         slot_cur = slot_ff;
         idx_cur  = idx_ff;
      end
      slot_in      = slot_cur + stride;
      idx_in       = idx_cur + idx_vc;
      k_in         = step ? (last ? '0 : k_ff + 1'b1) : k_ff;
      rsp_valid_in = step || (rsp_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         slot_ff       <= slot_in;
         idx_ff        <= idx_in;
         rsp_kind      <= q_head.mode;
         rsp_slot      <= slot_cur;
         rsp_last      <= last;
         if (is_index) begin
            rsp_out_x        <= '0;
            rsp_out_y        <= '0;
            rsp_out_z        <= '0;
            rsp_out_texcoord <= '0;
            rsp_out_rgb      <= '0;
            rsp_out_alpha    <= '0;
            rsp_index_out    <= last ? ogx_pkg::IDX_OUT_W'(q_head.index_in) : idx_cur;
         end else begin
            rsp_out_x        <= q_head.pos_x;
            rsp_out_y        <= ogx_pkg::shift_sat(q_head.pos_y, cfg.offset_y,
                                                   ogx_pkg::dir_y(k_ff[2:0]));
            rsp_out_z        <= ogx_pkg::shift_sat(q_head.pos_z, cfg.offset_z,
                                                   ogx_pkg::dir_z(k_ff[2:0]));
            rsp_out_texcoord <= q_head.texcoord;
            rsp_out_rgb      <= cfg.outline_color[ogx_pkg::RGB_W-1:0];
            rsp_out_alpha    <= q_head.alpha;
            rsp_index_out    <= '0;
         end
      end
   end

   assign rsp_empty = !rsp_valid_ff;

   a_item_held: assert property (@(posedge clock) disable iff (reset)
      (k_ff != '0) |-> q_valid)
      else $error("item left the queue mid expansion");
   a_copy_bound: assert property (@(posedge clock) disable iff (reset)
      k_ff <= ogx_pkg::COPY_W'(8))
      else $error("copy counter out of range");
   a_restart: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (k_ff == '0 && !rsp_empty && rsp_last))
      else $error("last beat not marked or counter not rewound");

endmodule

### sv/outline_geometry_expander.sv
// ----------------------------------------------------------------------------
// outline_geometry_expander
// Expands mesh vertices into shifted outline copies and triangle indices into
// offset index blocks.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  req       req_push / req_full    mode, position, xyz, texcoord, alpha, index
//  rsp       rsp_pop / rsp_empty    kind, slot, xyz, texcoord, rgb, alpha, index
//  csr       csr_valid / csr_ready  csr_index, csr_data
//
// One result beat per cycle from the expansion stage while the result register
// is free: a vertex item gives 4 or 8 beats, an index item 5 or 9, set by the
// copy counter in ogx_back. An item passes the input stage and the queue
// before its results are registered. Items are dropped without result while
// vertex_count or index_count is zero. Reset restores register defaults and
// empties the input stage, queue and result register. A held result stalls
// expansion; the two-entry queue keeps the input side taking items meanwhile.
// ----------------------------------------------------------------------------
module outline_geometry_expander (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic                                 req_mode,
   input  logic [ogx_pkg::POSN_W-1:0]           req_item_position,
   input  logic signed [ogx_pkg::POS_W-1:0]     req_pos_x,
   input  logic signed [ogx_pkg::POS_W-1:0]     req_pos_y,
   input  logic signed [ogx_pkg::POS_W-1:0]     req_pos_z,
   input  logic [ogx_pkg::TEX_W-1:0]            req_texcoord,
   input  logic [ogx_pkg::ALPHA_W-1:0]          req_source_alpha,
   input  logic [ogx_pkg::IDX_IN_W-1:0]         req_index_in,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic                                 rsp_kind,
   output logic [ogx_pkg::SLOT_W-1:0]           rsp_slot,
   output logic signed [ogx_pkg::POS_W-1:0]     rsp_out_x,
   output logic signed [ogx_pkg::POS_W-1:0]     rsp_out_y,
   output logic signed [ogx_pkg::POS_W-1:0]     rsp_out_z,
   output logic [ogx_pkg::TEX_W-1:0]            rsp_out_texcoord,
   output logic [ogx_pkg::RGB_W-1:0]            rsp_out_rgb,
   output logic [ogx_pkg::ALPHA_W-1:0]          rsp_out_alpha,
   output logic [ogx_pkg::IDX_OUT_W-1:0]        rsp_index_out,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ogx_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ogx_pkg::CSR_DATA_W-1:0]       csr_data
);

   ogx_pkg::cfg_type    cfg;
   ogx_pkg::entry_type  push_entry;
   ogx_pkg::entry_type  head;
   logic                q_push;
   logic                q_full;
   logic                q_pop;
   logic                q_valid;

   ogx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ogx_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_mode          (req_mode),
      .req_item_position (req_item_position),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_texcoord      (req_texcoord),
      .req_source_alpha  (req_source_alpha),
      .req_index_in      (req_index_in),
      .q_push            (q_push),
      .q_entry           (push_entry),
      .q_full            (q_full)
   );

   ogx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_valid),
      .head       (head)
   );

   ogx_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .q_valid          (q_valid),
      .q_head           (head),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_kind         (rsp_kind),
      .rsp_slot         (rsp_slot),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_z        (rsp_out_z),
      .rsp_out_texcoord (rsp_out_texcoord),
      .rsp_out_rgb      (rsp_out_rgb),
      .rsp_out_alpha    (rsp_out_alpha),
      .rsp_index_out    (rsp_index_out),
      .rsp_last         (rsp_last)
   );

endmodule

### dv/outline_geometry_expander_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// outline_geometry_expander_tb
// Drives vertex and index items through the expander, walks a directed table
// and then random register settings, and checks every result beat field by
// field against an in-bench model of the outline expansion.
// ----------------------------------------------------------------------------
module outline_geometry_expander_tb;

   localparam int SETTLE_CYCLES   = 16;
   localparam int RANDOM_PHASES   = 7;
   localparam int ITEMS_PER_PHASE = 60;
   localparam logic [ogx_pkg::POS_W-1:0] COORD_MAX = 24'h7FFFFF;
   localparam logic [ogx_pkg::POS_W-1:0] COORD_MIN = 24'h800000;

   typedef struct packed {
      logic                             kind;
      logic [ogx_pkg::SLOT_W-1:0]       slot;
      logic signed [ogx_pkg::POS_W-1:0] x;
      logic signed [ogx_pkg::POS_W-1:0] y;
      logic signed [ogx_pkg::POS_W-1:0] z;
      logic [ogx_pkg::TEX_W-1:0]        tex;
      logic [ogx_pkg::RGB_W-1:0]        rgb;
      logic [ogx_pkg::ALPHA_W-1:0]      alpha;
      logic [ogx_pkg::IDX_OUT_W-1:0]    index;
      logic                             last;
   } beat_type;

   // one line of the directed script: a register write or an item, the latter
   // optionally with the first beat's Y, Z and alpha pinned by hand
   typedef struct packed {
      logic                             is_csr;
      logic [ogx_pkg::CSR_INDEX_W-1:0]  csr_index;
      logic [ogx_pkg::CSR_DATA_W-1:0]   csr_data;
      ogx_pkg::entry_type               item;
      logic                             pinned;
      logic                             no_result;
      logic signed [ogx_pkg::POS_W-1:0] first_y;
      logic signed [ogx_pkg::POS_W-1:0] first_z;
      logic [ogx_pkg::ALPHA_W-1:0]      first_alpha;
   } row_type;

   logic                             clock;
   logic                             reset;
   logic                             req_push;
   logic                             req_full;
   logic                             req_mode;
   logic [ogx_pkg::POSN_W-1:0]       req_item_position;
   logic signed [ogx_pkg::POS_W-1:0] req_pos_x;
   logic signed [ogx_pkg::POS_W-1:0] req_pos_y;
   logic signed [ogx_pkg::POS_W-1:0] req_pos_z;
   logic [ogx_pkg::TEX_W-1:0]        req_texcoord;
   logic [ogx_pkg::ALPHA_W-1:0]      req_source_alpha;
   logic [ogx_pkg::IDX_IN_W-1:0]     req_index_in;
   logic                             rsp_empty;
   logic                             rsp_pop;
   logic                             rsp_kind;
   logic [ogx_pkg::SLOT_W-1:0]       rsp_slot;
   logic signed [ogx_pkg::POS_W-1:0] rsp_out_x;
   logic signed [ogx_pkg::POS_W-1:0] rsp_out_y;
   logic signed [ogx_pkg::POS_W-1:0] rsp_out_z;
   logic [ogx_pkg::TEX_W-1:0]        rsp_out_texcoord;
   logic [ogx_pkg::RGB_W-1:0]        rsp_out_rgb;
   logic [ogx_pkg::ALPHA_W-1:0]      rsp_out_alpha;
   logic [ogx_pkg::IDX_OUT_W-1:0]    rsp_index_out;
   logic                             rsp_last;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [ogx_pkg::CSR_INDEX_W-1:0]  csr_index;
   logic [ogx_pkg::CSR_DATA_W-1:0]   csr_data;

   ogx_pkg::cfg_type shadow_cfg;
   beat_type         awaited_beats[$];
   row_type          directed_rows[$];
   int               mismatches;
   bit               steady;

   outline_geometry_expander dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_mode         (req_mode),
      .req_item_position(req_item_position),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_texcoord     (req_texcoord),
      .req_source_alpha (req_source_alpha),
      .req_index_in     (req_index_in),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_kind         (rsp_kind),
      .rsp_slot         (rsp_slot),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_out_z        (rsp_out_z),
      .rsp_out_texcoord (rsp_out_texcoord),
      .rsp_out_rgb      (rsp_out_rgb),
      .rsp_out_alpha    (rsp_out_alpha),
      .rsp_index_out    (rsp_index_out),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("outline_geometry_expander_tb: errors");
      $finish;
   end

   // sign of the offset applied to copy k, in the order
   // (+,+) (-,+) (+,-) (-,-) (-,0) (+,0) (0,+) (0,-)
   function automatic int copy_sign(input bit z_axis, input int k);
      int s;
      case (k)
         0:       s = 1;
         1:       s = z_axis ? 1 : -1;
         2:       s = z_axis ? -1 : 1;
         3:       s = -1;
         4:       s = z_axis ? 0 : -1;
         5:       s = z_axis ? 0 : 1;
         6:       s = z_axis ? 1 : 0;
         default: s = z_axis ? -1 : 0;
      endcase
      return s;
   endfunction

   function automatic logic signed [ogx_pkg::POS_W-1:0] clamp_shift(
      input logic signed [ogx_pkg::POS_W-1:0] v,
      input logic signed [ogx_pkg::POS_W-1:0] off,
      input int                               s);
      longint t;
      t = longint'(v) + longint'(s) * longint'(off);
      if (t > 64'sd8388607) t = 64'sd8388607;
      if (t < -64'sd8388608) t = -64'sd8388608;
      return t[ogx_pkg::POS_W-1:0];
   endfunction

   // queue up every beat that one accepted item should produce
   function automatic void expand_item(input ogx_pkg::entry_type it);
      int       copies;
      longint   vc;
      longint   ic;
      longint   alpha;
      longint   val;
      beat_type b;
      copies = shadow_cfg.use_eight ? 8 : 4;
      vc     = longint'(shadow_cfg.vertex_count);
      ic     = longint'(shadow_cfg.index_count);
      if (vc == 0 || ic == 0) return;
      if (it.mode == ogx_pkg::KIND_VERTEX) begin
         alpha = longint'(shadow_cfg.outline_color[31:24]);
         if (shadow_cfg.mult_alpha) alpha = (longint'(it.alpha) * alpha) / 255;
         for (int k = 0; k < copies; k++) begin
            b       = '0;
            b.kind  = ogx_pkg::KIND_VERTEX;
            b.slot  = ogx_pkg::SLOT_W'(longint'(k + 1) * vc + longint'(it.position));
            b.x     = it.pos_x;
            b.y     = clamp_shift(it.pos_y, shadow_cfg.offset_y, copy_sign(1'b0, k));
            b.z     = clamp_shift(it.pos_z, shadow_cfg.offset_z, copy_sign(1'b1, k));
            b.tex   = it.texcoord;
            b.rgb   = shadow_cfg.outline_color[23:0];
            b.alpha = alpha[ogx_pkg::ALPHA_W-1:0];
            b.last  = (k == copies - 1);
            awaited_beats.push_back(b);
         end
      end else begin
         for (int k = 0; k <= copies; k++) begin
            val     = longint'(it.index_in);
            if (k < copies) val = val + longint'(k + 1) * vc;
            b       = '0;
            b.kind  = ogx_pkg::KIND_INDEX;
            b.slot  = ogx_pkg::SLOT_W'(longint'(k) * ic + longint'(it.position));
            b.index = val[ogx_pkg::IDX_OUT_W-1:0];
            b.last  = (k == copies);
            awaited_beats.push_back(b);
         end
      end
   endfunction

   function automatic row_type item_row(
      input logic                             mode,
      input logic [ogx_pkg::POSN_W-1:0]       position,
      input logic [ogx_pkg::POS_W-1:0]        x,
      input logic [ogx_pkg::POS_W-1:0]        y,
      input logic [ogx_pkg::POS_W-1:0]        z,
      input logic [ogx_pkg::TEX_W-1:0]        tex,
      input logic [ogx_pkg::ALPHA_W-1:0]      alpha,
      input logic [ogx_pkg::IDX_IN_W-1:0]     index_in,
      input logic                             pinned,
      input logic                             no_result,
      input logic [ogx_pkg::POS_W-1:0]        first_y,
      input logic [ogx_pkg::POS_W-1:0]        first_z,
      input logic [ogx_pkg::ALPHA_W-1:0]      first_alpha);
      row_type r;
      r                 = '0;
      r.item.mode       = mode;
      r.item.position   = position;
      r.item.pos_x      = x;
      r.item.pos_y      = y;
      r.item.pos_z      = z;
      r.item.texcoord   = tex;
      r.item.alpha      = alpha;
      r.item.index_in   = index_in;
      r.pinned          = pinned;
      r.no_result       = no_result;
      r.first_y         = first_y;
      r.first_z         = first_z;
      r.first_alpha     = first_alpha;
      return r;
   endfunction

   function automatic row_type csr_row(input logic [ogx_pkg::CSR_INDEX_W-1:0] idx,
                                       input logic [ogx_pkg::CSR_DATA_W-1:0]  data);
      row_type r;
      r           = '0;
      r.is_csr    = 1'b1;
      r.csr_index = idx;
      r.csr_data  = data;
      return r;
   endfunction

   // coordinates and offsets lean toward the saturation corners
   function automatic logic [ogx_pkg::POS_W-1:0] rand_coord();
      logic [ogx_pkg::POS_W-1:0] c;
      case ($urandom_range(0, 3))
         0:       c = ogx_pkg::POS_W'($urandom);
         1:       c = ogx_pkg::POS_W'(COORD_MAX - $urandom_range(0, 1023));
         2:       c = ogx_pkg::POS_W'(COORD_MIN + $urandom_range(0, 1023));
         default: c = ogx_pkg::POS_W'($urandom_range(0, 4095) - 2048);
      endcase
      return c;
   endfunction

   function automatic row_type random_row();
      return item_row(1'($urandom), ogx_pkg::POSN_W'($urandom), rand_coord(),
                      rand_coord(), rand_coord(), $urandom, ogx_pkg::ALPHA_W'($urandom),
                      ogx_pkg::IDX_IN_W'($urandom), 1'b0, 1'b0, '0, '0, '0);
   endfunction

   task automatic send_item(input row_type r);
      int       gap;
      int       head;
      beat_type b;
      gap = steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push          <= 1'b1;
      req_mode          <= r.item.mode;
      req_item_position <= r.item.position;
      req_pos_x         <= r.item.pos_x;
      req_pos_y         <= r.item.pos_y;
      req_pos_z         <= r.item.pos_z;
      req_texcoord      <= r.item.texcoord;
      req_source_alpha  <= r.item.alpha;
      req_index_in      <= r.item.index_in;
      do @(posedge clock); while (req_full);
      if (!(r.pinned && r.no_result)) begin
         head = awaited_beats.size();
         expand_item(r.item);
         if (r.pinned && awaited_beats.size() > head) begin
            b                   = awaited_beats[head];
            b.y                 = r.first_y;
            b.z                 = r.first_z;
            b.alpha             = r.first_alpha;
            awaited_beats[head] = b;
         end
      end
      @(negedge clock);
   endtask

   // only write registers once the block has gone quiet
   task automatic csr_write(input logic [ogx_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [ogx_pkg::CSR_DATA_W-1:0]  data);
      logic [ogx_pkg::VCOUNT_W-1:0] vc;
      logic [ogx_pkg::ICOUNT_W-1:0] ic;
      req_push <= 1'b0;
      while (awaited_beats.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      vc = data[ogx_pkg::VCOUNT_W-1:0];
      ic = data[ogx_pkg::ICOUNT_W-1:0];
      case (idx)
         ogx_pkg::CSR_USE_EIGHT:     shadow_cfg.use_eight     = data[0];
         ogx_pkg::CSR_MULT_ALPHA:    shadow_cfg.mult_alpha    = data[0];
         ogx_pkg::CSR_OFFSET_Y:      shadow_cfg.offset_y      = data[ogx_pkg::POS_W-1:0];
         ogx_pkg::CSR_OFFSET_Z:      shadow_cfg.offset_z      = data[ogx_pkg::POS_W-1:0];
         ogx_pkg::CSR_OUTLINE_COLOR: shadow_cfg.outline_color = data;
         ogx_pkg::CSR_VERTEX_COUNT:
            shadow_cfg.vertex_count = (vc > ogx_pkg::VCOUNT_W'(ogx_pkg::MAX_VERTICES))
               ? ogx_pkg::VCOUNT_W'(ogx_pkg::MAX_VERTICES) : vc;
         ogx_pkg::CSR_INDEX_COUNT:
            shadow_cfg.index_count = (ic > ogx_pkg::ICOUNT_W'(ogx_pkg::MAX_INDICES))
               ? ogx_pkg::ICOUNT_W'(ogx_pkg::MAX_INDICES) : ic;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic field_check(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // result side: random stalls, compare each beat with the oldest expectation
   initial begin : rsp_side
      int       stall;
      beat_type want;
      beat_type got;
      @(negedge reset);
      @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         got = {rsp_kind, rsp_slot, rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_texcoord,
                rsp_out_rgb, rsp_out_alpha, rsp_index_out, rsp_last};
         if (awaited_beats.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected beat, expected none, actual slot %h", $time, rsp_slot);
         end else begin
            want = awaited_beats.pop_front();
            field_check("kind", 32'(want.kind), 32'(got.kind));
            field_check("slot", 32'(want.slot), 32'(got.slot));
            field_check("out_x", 32'(want.x), 32'(got.x));
            field_check("out_y", 32'(want.y), 32'(got.y));
            field_check("out_z", 32'(want.z), 32'(got.z));
            field_check("out_texcoord", want.tex, got.tex);
            field_check("out_rgb", 32'(want.rgb), 32'(got.rgb));
            field_check("out_alpha", 32'(want.alpha), 32'(got.alpha));
            field_check("index_out", 32'(want.index), 32'(got.index));
            field_check("last", 32'(want.last), 32'(got.last));
         end
         @(negedge clock);
      end
   end

   initial begin : req_side
      logic [ogx_pkg::CSR_DATA_W-1:0] vc_data;
      logic [ogx_pkg::CSR_DATA_W-1:0] ic_data;
      reset             = 1'b1;
      req_push          = 1'b0;
      req_mode          = ogx_pkg::KIND_VERTEX;
      req_item_position = '0;
      req_pos_x         = '0;
      req_pos_y         = '0;
      req_pos_z         = '0;
      req_texcoord      = '0;
      req_source_alpha  = '0;
      req_index_in      = '0;
      rsp_pop           = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = ogx_pkg::CSR_USE_EIGHT;
      csr_data          = '0;
      mismatches        = 0;
      steady            = 1'b0;
      shadow_cfg        = '{use_eight: 1'b0, mult_alpha: 1'b0, offset_y: 24'sd256,
                            offset_z: 24'sd256, outline_color: 32'hFF00_0000,
                            vertex_count: '0, index_count: '0};

      // empty mesh after reset, then with only the vertex count set
      directed_rows.push_back(item_row(ogx_pkg::KIND_VERTEX, 14'd7, 24'h000100,
         24'h000200, 24'h000300, 32'h0, 8'hFF, 12'd0, 1'b1, 1'b1, '0, '0, '0));
      directed_rows.push_back(item_row(ogx_pkg::KIND_INDEX, 14'd1, '0, '0, '0, '0, '0,
         12'd5, 1'b1, 1'b1, '0, '0, '0));
      directed_rows.push_back(csr_row(ogx_pkg::CSR_VERTEX_COUNT, 32'd5));
      directed_rows.push_back(item_row(ogx_pkg::KIND_VERTEX, 14'd2, '0, '0, '0, '0, 8'd9,
         '0, 1'b1, 1'b1, '0, '0, '0));
      // counts above the bounds, largest offsets, eight copies, scaled alpha
      directed_rows.push_back(csr_row(ogx_pkg::CSR_INDEX_COUNT, 32'hFFFF_FFFF));
      directed_rows.push_back(csr_row(ogx_pkg::CSR_VERTEX_COUNT, 32'd8191));
      directed_rows.push_back(csr_row(ogx_pkg::CSR_USE_EIGHT, 32'd1));
      directed_rows.push_back(csr_row(ogx_pkg::CSR_MULT_ALPHA, 32'd1));
      directed_rows.push_back(csr_row(ogx_pkg::CSR_OFFSET_Y, {8'hA5, COORD_MAX}));
      directed_rows.push_back(csr_row(ogx_pkg::CSR_OFFSET_Z, {8'h00, COORD_MIN}));
      directed_rows.push_back(csr_row(ogx_pkg::CSR_OUTLINE_COLOR, 32'hFFFF_FFFF));
      directed_rows.push_back(csr_row(ogx_pkg::CSR_NO_REG, 32'hFFFF_FFFF));
      directed_rows.push_back(item_row(ogx_pkg::KIND_VERTEX, 14'h3FFF, COORD_MIN,
         COORD_MAX, COORD_MIN, 32'hFFFF_FFFF, 8'hFF, '0, 1'b1, 1'b0, COORD_MAX,
         COORD_MIN, 8'hFF));
      directed_rows.push_back(item_row(ogx_pkg::KIND_VERTEX, 14'd0, COORD_MAX, '0, '0,
         '0, 8'd0, 12'hFFF, 1'b1, 1'b0, COORD_MAX, COORD_MIN, 8'd0));
      directed_rows.push_back(item_row(ogx_pkg::KIND_VERTEX, 14'd100, 24'h000001,
         COORD_MIN, COORD_MAX, 32'h8000_0001, 8'd128, '0, 1'b1, 1'b0, 24'hFFFFFF,
         24'hFFFFFF, 8'd128));
      directed_rows.push_back(item_row(ogx_pkg::KIND_INDEX, 14'h3FFF, '0, '0, '0, '0,
         '0, 12'hFFF, 1'b1, 1'b0, '0, '0, '0));
      directed_rows.push_back(item_row(ogx_pkg::KIND_INDEX, 14'd0, '0, '0, '0, '0, '0,
         12'd0, 1'b1, 1'b0, '0, '0, '0));
      // four copies, opposite offset corners, plain alpha, counts at the bounds
      directed_rows.push_back(csr_row(ogx_pkg::CSR_USE_EIGHT, 32'd0));
      directed_rows.push_back(csr_row(ogx_pkg::CSR_MULT_ALPHA, 32'd0));
      directed_rows.push_back(csr_row(ogx_pkg::CSR_OFFSET_Y, {8'h00, COORD_MIN}));
      directed_rows.push_back(csr_row(ogx_pkg::CSR_OFFSET_Z, {8'h00, COORD_MAX}));
      directed_rows.push_back(csr_row(ogx_pkg::CSR_OUTLINE_COLOR, 32'h8012_3456));
      directed_rows.push_back(csr_row(ogx_pkg::CSR_VERTEX_COUNT,
         32'(ogx_pkg::MAX_VERTICES)));
      directed_rows.push_back(csr_row(ogx_pkg::CSR_INDEX_COUNT,
         32'(ogx_pkg::MAX_INDICES)));
      directed_rows.push_back(item_row(ogx_pkg::KIND_VERTEX, 14'd4095, 24'h123456,
         COORD_MIN, COORD_MAX, 32'h0F0F_F0F0, 8'd37, '0, 1'b1, 1'b0, COORD_MIN,
         COORD_MAX, 8'h80));
      directed_rows.push_back(item_row(ogx_pkg::KIND_INDEX, 14'd4095, '0, '0, '0, '0,
         '0, 12'd77, 1'b1, 1'b0, '0, '0, '0));
      // small strides and fractional offsets, zero outline alpha
      directed_rows.push_back(csr_row(ogx_pkg::CSR_OUTLINE_COLOR, 32'h00AB_CDEF));
      directed_rows.push_back(csr_row(ogx_pkg::CSR_MULT_ALPHA, 32'd1));
      directed_rows.push_back(csr_row(ogx_pkg::CSR_OFFSET_Y, 32'h0000_0180));
      directed_rows.push_back(csr_row(ogx_pkg::CSR_OFFSET_Z, 32'h00FF_FF00));
      directed_rows.push_back(csr_row(ogx_pkg::CSR_VERTEX_COUNT, 32'd1));
      directed_rows.push_back(csr_row(ogx_pkg::CSR_INDEX_COUNT, 32'd3));
      directed_rows.push_back(item_row(ogx_pkg::KIND_VERTEX, 14'd3, 24'h01E240,
         24'h001000, 24'hFFF000, 32'h1234_5678, 8'd200, '0, 1'b0, 1'b0, '0, '0, '0));
      directed_rows.push_back(item_row(ogx_pkg::KIND_INDEX, 14'd2, '0, '0, '0, '0, '0,
         12'd7, 1'b0, 1'b0, '0, '0, '0));
      directed_rows.push_back(item_row(ogx_pkg::KIND_VERTEX, 14'h2AAA, 24'h555555,
         24'hAAAAAA, 24'h555555, 32'hAAAA_5555, 8'h55, 12'hAAA, 1'b0, 1'b0, '0, '0,
         '0));
      // bound plus one, zero Y offset, eight copies again
      directed_rows.push_back(csr_row(ogx_pkg::CSR_VERTEX_COUNT, 32'd4097));
      directed_rows.push_back(csr_row(ogx_pkg::CSR_INDEX_COUNT, 32'd16385));
      directed_rows.push_back(csr_row(ogx_pkg::CSR_USE_EIGHT, 32'd1));
      directed_rows.push_back(csr_row(ogx_pkg::CSR_OFFSET_Y, 32'd0));
      directed_rows.push_back(item_row(ogx_pkg::KIND_VERTEX, 14'd9, 24'hFFFFFF,
         COORD_MAX, 24'h7FFF00, 32'h0000_FFFF, 8'd254, '0, 1'b0, 1'b0, '0, '0, '0));
      directed_rows.push_back(item_row(ogx_pkg::KIND_INDEX, 14'h3FFF, '0, '0, '0, '0,
         '0, 12'hFFF, 1'b0, 1'b0, '0, '0, '0));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            csr_write(directed_rows[i].csr_index, directed_rows[i].csr_data);
         end else begin
            send_item(directed_rows[i]);
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         // zero counts stay rare so most phases produce results
         vc_data = ($urandom_range(0, 7) == 0) ? $urandom
                                               : $urandom_range(1, ogx_pkg::MAX_VERTICES);
         ic_data = ($urandom_range(0, 7) == 0) ? $urandom
                                               : $urandom_range(1, ogx_pkg::MAX_INDICES);
         csr_write(ogx_pkg::CSR_USE_EIGHT, $urandom);
         csr_write(ogx_pkg::CSR_MULT_ALPHA, $urandom);
         csr_write(ogx_pkg::CSR_OFFSET_Y, {8'($urandom), rand_coord()});
         csr_write(ogx_pkg::CSR_OFFSET_Z, {8'($urandom), rand_coord()});
         csr_write(ogx_pkg::CSR_OUTLINE_COLOR, $urandom);
         csr_write(ogx_pkg::CSR_VERTEX_COUNT, vc_data);
         csr_write(ogx_pkg::CSR_INDEX_COUNT, ic_data);
         if (phase % 3 == 0) csr_write(ogx_pkg::CSR_NO_REG, $urandom);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            steady = ((n / 15) % 4 == 3);
            send_item(random_row());
         end
         steady = 1'b0;
      end

      req_push <= 1'b0;
      while (awaited_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("outline_geometry_expander_tb: clean");
      end else begin
         $display("outline_geometry_expander_tb: errors");
      end
      $finish;
   end

endmodule

### filelist.f
sv/ogx_pkg.sv
sv/ogx_csr.sv
sv/ogx_front.sv
sv/ogx_queue.sv
sv/ogx_back.sv
sv/outline_geometry_expander.sv
dv/outline_geometry_expander_tb.sv
